// ===== design/pifb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pifb_pkg
// Shared widths, control word layout and microcode for the IIR filter bank.
// ---------------------------------------------------------------------------
package pifb_pkg;

    localparam int DATA_BITS = 24;
    localparam int COEF_BITS = 16;
    localparam int COEF_FRAC = 12;
    localparam int PROD_BITS = DATA_BITS + COEF_BITS;
    localparam int ACC_BITS  = PROD_BITS + 4;
    localparam int RND_BITS  = ACC_BITS - COEF_FRAC;
    localparam int DIFF_BITS = RND_BITS + 1;
    localparam int CFG_BITS  = 48;
    localparam int IDX_BITS  = 3;
    localparam int PC_BITS   = 3;

    // register indexes and coefficient selects share the same codes
    localparam logic [IDX_BITS-1:0] REG_B0   = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_B1   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_B2   = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_A1   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_A2   = 3'd4;
    localparam int                  NUM_REGS = 5;

    localparam logic [1:0] DSEL_W1  = 2'd0;
    localparam logic [1:0] DSEL_W2  = 2'd1;
    localparam logic [1:0] DSEL_NEW = 2'd2;

    localparam logic [1:0] ACC_NONE    = 2'd0;
    localparam logic [1:0] ACC_FB_LOAD = 2'd1;
    localparam logic [1:0] ACC_FB_ADD  = 2'd2;
    localparam logic [1:0] ACC_OUT_ADD = 2'd3;

    localparam logic signed [DIFF_BITS-1:0] SAT_HI = DIFF_BITS'(2 ** (DATA_BITS - 1) - 1);
    localparam logic signed [DIFF_BITS-1:0] SAT_LO = -SAT_HI - DIFF_BITS'(1);
    localparam logic signed [ACC_BITS-1:0]  RND_HALF = ACC_BITS'(2 ** (COEF_FRAC - 1));

    typedef struct packed {
        logic [IDX_BITS-1:0] coef_sel;
        logic [1:0]          data_sel;
        logic [1:0]          acc_op;
        logic                w_calc;
        logic                shift;
        logic                loop;
        logic                finish;
    } ctrl_word_t;

    typedef struct packed {
        ctrl_word_t word;
        logic       active;
        logic       start;
        logic       done;
    } seq_ctrl_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] value;
        logic                        ovf;
    } sat_t;

    function automatic sat_t sat_data(input logic signed [DIFF_BITS-1:0] v);
        sat_t r;
        r.ovf = 1'b1;
        if (v > SAT_HI) begin
            r.value = SAT_HI[DATA_BITS-1:0];
        end else if (v < SAT_LO) begin
            r.value = SAT_LO[DATA_BITS-1:0];
        end else begin
            r.value = v[DATA_BITS-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

    // floor((v + half) / 2^frac)
    function automatic logic signed [RND_BITS-1:0] round_q12(
        input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] t;
        t = v + RND_HALF;
        return t[ACC_BITS-1:COEF_FRAC];
    endfunction

    // per-section program; products land one step after their multiply
    function automatic ctrl_word_t ucode(input logic [PC_BITS-1:0] pc);
        ctrl_word_t w;
        w = '0;
        unique case (pc)
            3'd0: begin
                w.coef_sel = REG_A1;
                w.data_sel = DSEL_W1;
            end
            3'd1: begin
                w.coef_sel = REG_A2;
                w.data_sel = DSEL_W2;
                w.acc_op   = ACC_FB_LOAD;
            end
            3'd2: begin
                w.coef_sel = REG_B1;
                w.data_sel = DSEL_W1;
                w.acc_op   = ACC_FB_ADD;
            end
            3'd3: begin
                w.coef_sel = REG_B2;
                w.data_sel = DSEL_W2;
                w.acc_op   = ACC_OUT_ADD;
                w.w_calc   = 1'b1;
            end
            3'd4: begin
                w.coef_sel = REG_B0;
                w.data_sel = DSEL_NEW;
                w.acc_op   = ACC_OUT_ADD;
            end
            3'd5: begin
                w.acc_op = ACC_OUT_ADD;
                w.shift  = 1'b1;
                w.loop   = 1'b1;
            end
            3'd6: begin
                w.finish = 1'b1;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// ===== design/pifb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pifb channel interfaces
// Sample, result and register-write channels with valid/ready.
// ---------------------------------------------------------------------------
interface pifb_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface pifb_out_if;
    logic                                valid;
    logic                                ready;
    logic [pifb_pkg::DATA_BITS-1:0]      filtered_sum;
    logic                                overflow;

    modport source (output valid, output filtered_sum, output overflow, input ready);
    modport sink   (input valid, input filtered_sum, input overflow, output ready);
endinterface

interface pifb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pifb_pkg::IDX_BITS-1:0]  index;
    logic [pifb_pkg::CFG_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/pifb_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pifb_seq
// Step counter and microcode fetch; loops the section program NSECT times.
// ---------------------------------------------------------------------------
module pifb_seq #(
    parameter int NSECT = 3
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           in_valid,
    input  wire logic                                           out_full,
    output      logic                                           busy,
    output      pifb_pkg::seq_ctrl_t                            ctrl,
    output      logic [(NSECT > 1 ? $clog2(NSECT) : 1)-1:0]     sect
);
    localparam int SIDX_W = (NSECT > 1) ? $clog2(NSECT) : 1;

    logic [pifb_pkg::PC_BITS-1:0] pc_reg, pc_next;
    logic [SIDX_W-1:0]            sect_reg, sect_next;
    logic                         busy_reg, busy_next;
    pifb_pkg::ctrl_word_t         word;
    logic                         start;
    logic                         done;

    always_comb
    begin
        word  = pifb_pkg::ucode(pc_reg);
        start = in_valid && !busy_reg;
        done  = busy_reg && word.finish && !out_full;
    end

    always_comb
    begin
        pc_next   = pc_reg;
        sect_next = sect_reg;
        busy_next = busy_reg;
        if (start) begin
            busy_next = 1'b1;
            pc_next   = '0;
            sect_next = '0;
        end else if (busy_reg) begin
            if (word.finish) begin
                // hold on the last step while the result register is full
                if (!out_full) begin
                    busy_next = 1'b0;
                end
            end else if (word.loop && (sect_reg != SIDX_W'(NSECT - 1))) begin
                pc_next   = '0;
                sect_next = sect_reg + SIDX_W'(1);
            end else begin
                pc_next = pc_reg + pifb_pkg::PC_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg   <= '0;
            sect_reg <= '0;
            busy_reg <= 1'b0;
        end else begin
            pc_reg   <= pc_next;
            sect_reg <= sect_next;
            busy_reg <= busy_next;
        end
    end

    always_comb
    begin
        ctrl.word   = word;
        ctrl.active = busy_reg;
        ctrl.start  = start;
        ctrl.done   = done;
        busy        = busy_reg;
        sect        = sect_reg;
    end

endmodule
`default_nettype wire

// ===== design/pifb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pifb_datapath
// Shared multiplier, feedback and output accumulators, section delay rows.
// ---------------------------------------------------------------------------
module pifb_datapath #(
    parameter int NSECT        = 3,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire pifb_pkg::seq_ctrl_t                           ctrl,
    input  wire logic [(NSECT > 1 ? $clog2(NSECT) : 1)-1:0]    sect,
    input  wire logic signed [pifb_pkg::COEF_BITS-1:0]         coef,
    input  wire logic [SAMPLE_WIDTH-1:0]                       sample,
    output      pifb_pkg::sat_t                                result
);
    localparam int DW = pifb_pkg::DATA_BITS;
    localparam int AW = pifb_pkg::ACC_BITS;
    localparam int PW = pifb_pkg::PROD_BITS;
    localparam int FW = pifb_pkg::DIFF_BITS;

    logic signed [DW-1:0] w1_reg [NSECT];
    logic signed [DW-1:0] w2_reg [NSECT];
    logic signed [DW-1:0] x_reg;
    logic signed [DW-1:0] w_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] fb_reg;
    logic signed [AW-1:0] out_reg;
    logic                 ovf_reg;

    logic signed [SAMPLE_WIDTH-1:0] sample_s;
    logic signed [DW-1:0]           operand;
    logic signed [FW-1:0]           diff;
    pifb_pkg::sat_t                 w_sat;
    pifb_pkg::sat_t                 y_sat;

    always_comb
    begin
        sample_s = sample;
        unique case (ctrl.word.data_sel)
            pifb_pkg::DSEL_W1:  operand = w1_reg[sect];
            pifb_pkg::DSEL_W2:  operand = w2_reg[sect];
            pifb_pkg::DSEL_NEW: operand = w_reg;
            default:            operand = '0;
        endcase
        diff  = FW'(x_reg) - FW'(pifb_pkg::round_q12(fb_reg));
        w_sat = pifb_pkg::sat_data(diff);
        y_sat = pifb_pkg::sat_data(FW'(pifb_pkg::round_q12(out_reg)));
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * operand;
        if (ctrl.start) begin
            x_reg   <= DW'(sample_s);
            out_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (ctrl.active) begin
            unique case (ctrl.word.acc_op)
                pifb_pkg::ACC_FB_LOAD: fb_reg  <= AW'(prod_reg);
                pifb_pkg::ACC_FB_ADD:  fb_reg  <= fb_reg + AW'(prod_reg);
                pifb_pkg::ACC_OUT_ADD: out_reg <= out_reg + AW'(prod_reg);
                default:               ;
            endcase
            if (ctrl.word.w_calc) begin
                w_reg   <= w_sat.value;
                ovf_reg <= ovf_reg | w_sat.ovf;
            end
        end
    end

    // w2 <- w1, w1 <- w once the section's products are issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NSECT; i++) begin
                w1_reg[i] <= '0;
                w2_reg[i] <= '0;
            end
        end else if (ctrl.active && ctrl.word.shift) begin
            w2_reg[sect] <= w1_reg[sect];
            w1_reg[sect] <= w_reg;
        end
    end

    always_comb
    begin
        result.value = y_sat.value;
        result.ovf   = y_sat.ovf | ovf_reg;
    end

endmodule
`default_nettype wire

// ===== design/parallel_iir_filter_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// parallel_iir_filter_bank
// Parallel bank of second-order direct-form-II IIR sections, summed output.
// ---------------------------------------------------------------------------
// samples: one signed sample word per handshake, taken only while the bank
//   is idle (ready low while a sample is being worked on).
// results: one word per sample, the rounded and saturated sum of all
//   sections plus an overflow flag; held in an output register until taken.
// cfg: register writes (b0, b1, b2, a1, a2 packs, 16 bits per section),
//   always ready, writes to unknown indexes are dropped; write only when idle.
// timing: a microcoded loop drives one 16x24 multiplier, six steps per
//   section plus one finishing step; the result register loads on the
//   finishing step, which also ends the busy state, and only then is the
//   next sample taken: a new sample waits until the last one is done.
// stall: if the previous result is still waiting, the finishing step holds
//   until the output register frees up.
// reset: coefficients and section delays clear to zero, no result pending.
// ---------------------------------------------------------------------------
module parallel_iir_filter_bank #(
    parameter int NSECT        = 3,
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pifb_in_if.sink    samples,
    pifb_out_if.source results,
    pifb_cfg_if.sink   cfg
);
    localparam int SIDX_W = (NSECT > 1) ? $clog2(NSECT) : 1;
    localparam int CW     = pifb_pkg::COEF_BITS;
    localparam int KW     = NSECT * CW;

    logic [KW-1:0]                   coef_reg [pifb_pkg::NUM_REGS];
    logic                            res_valid_reg;
    logic [pifb_pkg::DATA_BITS-1:0]  res_sum_reg;
    logic                            res_ovf_reg;

    pifb_pkg::seq_ctrl_t             ctrl;
    logic [SIDX_W-1:0]               sect;
    logic                            busy;
    logic                            out_full;
    logic signed [CW-1:0]            coef;
    pifb_pkg::sat_t                  result;

    assign out_full      = res_valid_reg && !results.ready;
    assign samples.ready = !busy;
    assign cfg.ready     = 1'b1;

    always_comb
    begin
        if (ctrl.word.coef_sel < pifb_pkg::IDX_BITS'(pifb_pkg::NUM_REGS)) begin
            coef = coef_reg[ctrl.word.coef_sel][sect * CW +: CW];
        end else begin
            coef = '0;
        end
    end

    pifb_seq #(
        .NSECT (NSECT)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .out_full (out_full),
        .busy     (busy),
        .ctrl     (ctrl),
        .sect     (sect)
    );

    pifb_datapath #(
        .NSECT        (NSECT),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sect   (sect),
        .coef   (coef),
        .sample (samples.sample_in),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < pifb_pkg::NUM_REGS; i++) begin
                coef_reg[i] <= '0;
            end
        end else if (cfg.valid
                     && (cfg.index < pifb_pkg::IDX_BITS'(pifb_pkg::NUM_REGS))) begin
            coef_reg[cfg.index] <= cfg.data[KW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (ctrl.done) begin
            res_valid_reg <= 1'b1;
        end else if (results.ready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done) begin
            res_sum_reg <= result.value;
            res_ovf_reg <= result.ovf;
        end
    end

    assign results.valid        = res_valid_reg;
    assign results.filtered_sum = res_sum_reg;
    assign results.overflow     = res_ovf_reg;

endmodule
`default_nettype wire
